### hw/rtl/kvrc_pkg.sv
// kvrc_pkg: shared types for the key/value run compactor
// entry and result beat layouts, and the control group driven into the cell chain
// no dependencies
package kvrc_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ValueW = 64;

  typedef struct packed {
    logic [KeyW-1:0]   entry_key;
    logic [ValueW-1:0] entry_value;
    logic              tombstone;
    logic              batch_end;
  } entry_t;

  typedef struct packed {
    logic              has_entry;
    logic [KeyW-1:0]   out_key;
    logic [ValueW-1:0] out_value;
    logic              overflowed;
    logic              last_result;
  } result_t;

  // one control word shared by every cell in the chain
  typedef struct packed {
    logic cmp;    // compare held key against the incoming key
    logic upd;    // key already held: overwrite the matching cell
    logic ins;    // new key: insert and shift the larger keys up
    logic drain;  // shift the whole chain down by one cell
  } cell_ctrl_t;

endpackage

### hw/rtl/kvrc_cell.sv
// kvrc_cell: one slot of the sorted insertion chain
// holds one key/value/tombstone entry and moves it to a neighbor on insert or drain
// depends on kvrc_pkg
module kvrc_cell #(
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kvrc_pkg::cell_ctrl_t   ctrl_i,
  input  logic [KEY_BITS-1:0]    cmp_key_i,
  input  logic [KEY_BITS-1:0]    new_key_i,
  input  logic [VALUE_BITS-1:0]  new_value_i,
  input  logic                   new_tomb_i,
  input  logic                   prev_valid_i,
  input  logic                   prev_gt_i,
  input  logic [KEY_BITS-1:0]    prev_key_i,
  input  logic [VALUE_BITS-1:0]  prev_value_i,
  input  logic                   prev_tomb_i,
  input  logic                   next_valid_i,
  input  logic [KEY_BITS-1:0]    next_key_i,
  input  logic [VALUE_BITS-1:0]  next_value_i,
  input  logic                   next_tomb_i,
  output logic                   valid_o,
  output logic                   gt_o,
  output logic                   eq_o,
  output logic [KEY_BITS-1:0]    key_o,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic                   tomb_o
);
  import kvrc_pkg::*;

  logic                  valid_q, gt_q, eq_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  tomb_q;
  logic                  take_prev, take_new;

  // larger keys move up one cell; the first cell past the smaller keys takes the new entry
  assign take_prev = prev_gt_i;
  assign take_new  = prev_valid_i & ~prev_gt_i & (~valid_q | gt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      if (ctrl_i.cmp) begin
        gt_q <= valid_q & (key_q > cmp_key_i);
        eq_q <= valid_q & (key_q == cmp_key_i);
      end
      if (ctrl_i.drain) begin
        valid_q <= next_valid_i;
      end else if (ctrl_i.ins && (take_prev || take_new)) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.drain) begin
      key_q   <= next_key_i;
      value_q <= next_value_i;
      tomb_q  <= next_tomb_i;
    end else if (ctrl_i.upd && eq_q) begin
      value_q <= new_value_i;
      tomb_q  <= new_tomb_i;
    end else if (ctrl_i.ins && take_prev) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
      tomb_q  <= prev_tomb_i;
    end else if (ctrl_i.ins && take_new) begin
      key_q   <= new_key_i;
      value_q <= new_value_i;
      tomb_q  <= new_tomb_i;
    end
  end

  assign valid_o = valid_q;
  assign gt_o    = gt_q;
  assign eq_o    = eq_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign tomb_o  = tomb_q;

endmodule

### hw/rtl/key_value_run_compactor_core.sv
// key_value_run_compactor_core: merges a compaction set into one sorted run
// an accepted entry is compared in every cell at the accept edge; in ST_INS, which follows,
// it overwrites its matching cell, is inserted, or is dropped when full (busy is high)
// after the batch-end entry, the drain emits one cell per cycle with busy high: one result beat
// per survivor, or an empty beat; the receiver cannot stall. reset clears the chain and control
// depends on kvrc_pkg and kvrc_cell
module key_value_run_compactor_core #(
  parameter int unsigned ENTRIES    = 64,
  parameter int unsigned KEY_BITS   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  kvrc_pkg::entry_t  entry_i,
  output logic              busy,
  output logic              result_valid_o,
  output kvrc_pkg::result_t result_o
);
  import kvrc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_INS   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic                  accept;
  logic [KEY_BITS-1:0]   new_key_q;
  logic [VALUE_BITS-1:0] new_value_q;
  logic                  new_tomb_q, end_q;
  logic                  ovf_q;
  logic                  pend_valid_q;
  logic [KEY_BITS-1:0]   pend_key_q;
  logic [VALUE_BITS-1:0] pend_value_q;
  logic                  res_valid_q;
  result_t               res_q;
  cell_ctrl_t            ctrl;
  logic                  any_eq, full;

  logic [ENTRIES-1:0]    c_valid, c_gt, c_eq, c_tomb;
  logic [KEY_BITS-1:0]   c_key   [ENTRIES];
  logic [VALUE_BITS-1:0] c_value [ENTRIES];

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign any_eq = |c_eq;
  assign full   = c_valid[ENTRIES-1];

  always_comb begin
    ctrl       = '0;
    ctrl.cmp   = accept;
    ctrl.upd   = (state_q == ST_INS) && any_eq;
    ctrl.ins   = (state_q == ST_INS) && !any_eq && !full;
    ctrl.drain = (state_q == ST_DRAIN);
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                  p_valid, p_gt, p_tomb, n_valid, n_tomb;
    logic [KEY_BITS-1:0]   p_key, n_key;
    logic [VALUE_BITS-1:0] p_value, n_value;

    if (i == 0) begin : g_head
      assign p_valid = 1'b1;
      assign p_gt    = 1'b0;
      assign p_key   = new_key_q;
      assign p_value = new_value_q;
      assign p_tomb  = new_tomb_q;
    end else begin : g_body
      assign p_valid = c_valid[i-1];
      assign p_gt    = c_gt[i-1];
      assign p_key   = c_key[i-1];
      assign p_value = c_value[i-1];
      assign p_tomb  = c_tomb[i-1];
    end

    if (i == ENTRIES-1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = new_key_q;
      assign n_value = new_value_q;
      assign n_tomb  = new_tomb_q;
    end else begin : g_mid
      assign n_valid = c_valid[i+1];
      assign n_key   = c_key[i+1];
      assign n_value = c_value[i+1];
      assign n_tomb  = c_tomb[i+1];
    end

    kvrc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmp_key_i    (entry_i.entry_key[KEY_BITS-1:0]),
      .new_key_i    (new_key_q),
      .new_value_i  (new_value_q),
      .new_tomb_i   (new_tomb_q),
      .prev_valid_i (p_valid),
      .prev_gt_i    (p_gt),
      .prev_key_i   (p_key),
      .prev_value_i (p_value),
      .prev_tomb_i  (p_tomb),
      .next_valid_i (n_valid),
      .next_key_i   (n_key),
      .next_value_i (n_value),
      .next_tomb_i  (n_tomb),
      .valid_o      (c_valid[i]),
      .gt_o         (c_gt[i]),
      .eq_o         (c_eq[i]),
      .key_o        (c_key[i]),
      .value_o      (c_value[i]),
      .tomb_o       (c_tomb[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (start) state_d = ST_INS;
      ST_INS:   state_d = end_q ? ST_DRAIN : ST_IDLE;
      ST_DRAIN: if (!c_valid[0]) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_key_q   <= entry_i.entry_key[KEY_BITS-1:0];
      new_value_q <= entry_i.entry_value[VALUE_BITS-1:0];
      new_tomb_q  <= entry_i.tombstone;
    end
    if (state_q == ST_DRAIN && c_valid[0] && !c_tomb[0]) begin
      pend_key_q   <= c_key[0];
      pend_value_q <= c_value[0];
    end
  end

  // a survivor is held back one step so the final beat can carry last_result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      end_q        <= 1'b0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == ST_DRAIN) &&
                     (!c_valid[0] || (!c_tomb[0] && pend_valid_q));
      if (accept) begin
        end_q <= entry_i.batch_end;
      end
      if (state_q == ST_INS && !any_eq && full) begin
        ovf_q <= 1'b1;
      end
      if (state_q == ST_DRAIN) begin
        if (c_valid[0]) begin
          if (!c_tomb[0]) begin
            pend_valid_q <= 1'b1;
            if (pend_valid_q) begin
              res_q.has_entry   <= 1'b1;
              res_q.out_key     <= KeyW'(pend_key_q);
              res_q.out_value   <= ValueW'(pend_value_q);
              res_q.overflowed  <= ovf_q;
              res_q.last_result <= 1'b0;
            end
          end
        end else begin
          res_q.has_entry   <= pend_valid_q;
          res_q.out_key     <= pend_valid_q ? KeyW'(pend_key_q) : '0;
          res_q.out_value   <= pend_valid_q ? ValueW'(pend_value_q) : '0;
          res_q.overflowed  <= ovf_q;
          res_q.last_result <= 1'b1;
          pend_valid_q      <= 1'b0;
          ovf_q             <= 1'b0;
        end
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // held entries always form a packed run from the bottom cell
  a_packed_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((c_valid >> 1) & ~c_valid) == '0)
    else $error("cell chain has a hole");

  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_result |-> state_q == ST_IDLE && !pend_valid_q)
    else $error("batch ended with work left");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.has_entry |-> result_o.last_result)
    else $error("empty result not marked last");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctrl.cmp, ctrl.upd, ctrl.ins, ctrl.drain}) <= 1)
    else $error("conflicting chain operations");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for key_value_run_compactor_core
// predicts each sorted run in a behavioral store and checks every result beat
// depends on kvrc_pkg and the compactor rtl
module tb_top;
  import kvrc_pkg::*;

  localparam int unsigned ENTRIES      = 64;
  localparam int unsigned KEY_BITS     = 64;
  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned RANDOM_ITEMS = 124;

  logic    clk;
  logic    rst_ni;
  logic    start;
  entry_t  entry_i;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  // behavioral copy of the sorted store
  logic [63:0] run_keys[ENTRIES];
  logic [63:0] run_values[ENTRIES];
  bit          run_tombs[ENTRIES];
  int          run_held;
  bit          run_overflow;

  result_t     pending_run[$];
  int unsigned mismatches;
  bit          idling;

  key_value_run_compactor_core #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .start         (start),
    .entry_i       (entry_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // absorb one entry; on the batch end, queue the whole sorted run
  function automatic void merge_entry(input entry_t e);
    logic [63:0] k;
    logic [63:0] v;
    int          pos;
    int          survivors;
    int          seen;
    result_t     r;
    k   = 64'(e.entry_key[KEY_BITS-1:0]);
    v   = 64'(e.entry_value[VALUE_BITS-1:0]);
    pos = 0;
    while (pos < run_held && run_keys[pos] < k) pos++;
    if (pos < run_held && run_keys[pos] == k) begin
      run_values[pos] = v;
      run_tombs[pos]  = e.tombstone;
    end else if (run_held >= ENTRIES) begin
      run_overflow = 1'b1;
    end else begin
      for (int i = run_held; i > pos; i--) begin
        run_keys[i]   = run_keys[i-1];
        run_values[i] = run_values[i-1];
        run_tombs[i]  = run_tombs[i-1];
      end
      run_keys[pos]   = k;
      run_values[pos] = v;
      run_tombs[pos]  = e.tombstone;
      run_held++;
    end
    if (!e.batch_end) return;
    survivors = 0;
    for (int i = 0; i < run_held; i++) if (!run_tombs[i]) survivors++;
    if (survivors == 0) begin
      r             = '0;
      r.overflowed  = run_overflow;
      r.last_result = 1'b1;
      pending_run   = {pending_run, r};
    end else begin
      seen = 0;
      for (int i = 0; i < run_held; i++) begin
        if (!run_tombs[i]) begin
          seen++;
          r.has_entry   = 1'b1;
          r.out_key     = run_keys[i];
          r.out_value   = run_values[i];
          r.overflowed  = run_overflow;
          r.last_result = (seen == survivors);
          pending_run   = {pending_run, r};
        end
      end
    end
    run_held     = 0;
    run_overflow = 1'b0;
  endfunction

  function automatic logic [63:0] pick_key();
    case ($urandom_range(3))
      0:       return 64'($urandom_range(7));
      1:       return 64'hFFFF_FFFF_FFFF_FFF8 | 64'($urandom_range(7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called at a rising edge; returns at the edge the beat was taken, or after a random gap when idling
  task automatic send_entry(input logic [63:0] k, input logic [63:0] v,
                            input bit tomb, input bit last);
    entry_t      e;
    int unsigned gap;
    e.entry_key   = k;
    e.entry_value = v;
    e.tombstone   = tomb;
    e.batch_end   = last;
    start   <= 1'b1;
    entry_i <= e;
    do @(posedge clk); while (busy);
    merge_entry(e);
    if (idling) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8:          gap = $urandom_range(3, 1);
        default:          gap = $urandom_range(20, 5);
      endcase
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold the sender until every queued beat has come back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_run.size() != 0);
  endtask

  task automatic test_directed();
    idling = 1'b1;
    // lone entry, key and value at both extremes
    send_entry(64'h0, 64'h0, 1'b0, 1'b1);
    send_entry('1, '1, 1'b0, 1'b1);
    // batch holding only a deletion gives the empty beat
    send_entry(64'd5, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
    // newer entry overwrites, unsigned ordering across the msb
    send_entry(64'd10, 64'h1111_1111_1111_1111, 1'b0, 1'b0);
    send_entry(64'd10, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
    send_entry(64'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
    send_entry('1, 64'h8000_0000_0000_0001, 1'b0, 1'b1);
    // deletion of an earlier key
    send_entry(64'd7, 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0);
    send_entry(64'd7, 64'h0, 1'b1, 1'b0);
    send_entry(64'd8, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b1);
    // every key deleted
    send_entry(64'd9, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
    send_entry(64'd9, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
    // deleted key brought back by a newer put
    send_entry(64'd4, 64'h0, 1'b1, 1'b0);
    send_entry(64'd4, 64'hDEAD_BEEF_0000_0001, 1'b0, 1'b1);
    // descending keys, each one lands at the front
    send_entry(64'h8000_0000_0000_0000, 64'h1, 1'b0, 1'b0);
    send_entry(64'h4000_0000_0000_0000, 64'h2, 1'b0, 1'b0);
    send_entry(64'h1, 64'h3, 1'b0, 1'b0);
    send_entry(64'h0, 64'h4, 1'b0, 1'b1);
    settle();
  endtask

  // fill the store, drop new keys, still overwrite a held one
  task automatic test_overflow();
    logic [63:0] used[$];
    logic [63:0] k;
    bit          fresh;
    idling = 1'b0;
    for (int i = 0; i < ENTRIES + 4; i++) begin
      if (i == ENTRIES + 1) begin
        k = used[$urandom_range(ENTRIES - 1)];
      end else begin
        do begin
          k     = {$urandom, $urandom};
          fresh = 1'b1;
          foreach (used[j]) if (used[j] == k) fresh = 1'b0;
        end while (!fresh);
        used = {used, k};
      end
      send_entry(k, {$urandom, $urandom},
                 (i == ENTRIES + 1) || ($urandom_range(7) == 0), i == ENTRIES + 3);
    end
    idling = 1'b1;
  endtask

  task automatic test_random_batches();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len    = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      idling = ($urandom_range(4) != 0);
      for (int i = 0; i < len; i++) begin
        send_entry(pick_key(), {$urandom, $urandom}, $urandom_range(3) == 0, i == len - 1);
      end
      sent += len;
      if (sent == len || $urandom_range(4) == 0) settle();
    end
    idling = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_run.size() == 0) begin
        $error("result beat with nothing expected: key %h", result_o.out_key);
        mismatches++;
      end else begin
        want = pending_run.pop_front();
        if (result_o.has_entry !== want.has_entry) begin
          $error("has_entry: expected %b, got %b", want.has_entry, result_o.has_entry);
          mismatches++;
        end
        if (result_o.out_key !== want.out_key) begin
          $error("out_key: expected %h, got %h", want.out_key, result_o.out_key);
          mismatches++;
        end
        if (result_o.out_value !== want.out_value) begin
          $error("out_value: expected %h, got %h", want.out_value, result_o.out_value);
          mismatches++;
        end
        if (result_o.overflowed !== want.overflowed) begin
          $error("overflowed: expected %b, got %b", want.overflowed, result_o.overflowed);
          mismatches++;
        end
        if (result_o.last_result !== want.last_result) begin
          $error("last_result: expected %b, got %b", want.last_result, result_o.last_result);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    entry_i      = '0;
    idling       = 1'b1;
    mismatches   = 0;
    run_held     = 0;
    run_overflow = 1'b0;
    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    test_directed();
    test_overflow();
    test_random_batches();
    settle();
    // a drain still in flight would show up as an unexpected beat here
    repeat (ENTRIES + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
